// ===== rtl/core/fir8_pkg.sv =====
// ----------------------------------------------------------------------------
// fir8_pkg
// Types and constants for the eight-tap Q1.15 low-pass FIR filter.
// ----------------------------------------------------------------------------
package fir8_pkg;

    localparam int TAPS       = 8;
    localparam int TAP_BITS   = 3;
    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int PSUM_W     = PROD_W + 2;
    localparam int ACC_W      = PROD_W + TAP_BITS;
    localparam int FRAC_BITS  = 15;
    localparam int SHIFTED_W  = ACC_W - FRAC_BITS;
    localparam int INDEX_W    = 4;

    typedef logic signed [SAMPLE_W-1:0]  sample_t;
    typedef logic signed [PROD_W-1:0]    prod_t;
    typedef logic signed [PSUM_W-1:0]    psum_t;
    typedef logic signed [ACC_W-1:0]     acc_t;
    typedef logic signed [SHIFTED_W-1:0] shifted_t;
    typedef logic [INDEX_W-1:0]          index_t;

    localparam index_t REG_COEF_LAST = index_t'(TAPS - 1);

    localparam shifted_t SAT_MAX = shifted_t'(32767);
    localparam shifted_t SAT_MIN = -shifted_t'(32768);

    localparam sample_t OUT_MAX = 16'sh7fff;
    localparam sample_t OUT_MIN = 16'sh8000;

    localparam sample_t COEF_RESET [TAPS] = '{
        16'sd328, 16'sd1638, 16'sd3932, 16'sd10486,
        16'sd10486, 16'sd3932, 16'sd1638, 16'sd328
    };

endpackage

// ===== rtl/core/fir_lowpass_8tap_top.sv =====
// ----------------------------------------------------------------------------
// fir_lowpass_8tap_top
// Eight-tap Q1.15 FIR low-pass filter with programmable coefficients,
// full-width accumulation, arithmetic shift by 15 and 16-bit saturation.
//
//   channel | handshake             | payload
//   --------+-----------------------+------------------------------
//   in      | in_valid / in_stall   | sample_in
//   out     | out_valid / out_stall | sample_out, saturated
//   config  | wr_en                 | wr_index, wr_data
//
// One sample per cycle sustained while out is not stalled; an accepted sample
// passes window, products, partial sums and output register to out_valid.
// The eight 16x16 multipliers in the product stage set the cycle.
// Reset clears the delay line, coefficients to their defaults, all valids.
// A stall on out backs up stage by stage; in_stall rises only when all
// four stages hold data.
// ----------------------------------------------------------------------------
module fir_lowpass_8tap_top
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  wr_en,
    input  fir8_pkg::index_t      wr_index,
    input  fir8_pkg::sample_t     wr_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  fir8_pkg::sample_t     sample_in,

    output logic                  out_valid,
    input  logic                  out_stall,
    output fir8_pkg::sample_t     sample_out,
    output logic                  saturated
);

    fir8_pkg::sample_t  coef_reg [fir8_pkg::TAPS];
    fir8_pkg::sample_t  win_reg  [fir8_pkg::TAPS];
    fir8_pkg::prod_t    prod_reg [fir8_pkg::TAPS];
    fir8_pkg::prod_t    prod_next [fir8_pkg::TAPS];
    fir8_pkg::psum_t    psum_reg [2];
    fir8_pkg::psum_t    psum_next [2];
    fir8_pkg::acc_t     acc;
    fir8_pkg::shifted_t shifted;
    fir8_pkg::sample_t  sample_out_next;
    logic               saturated_next;

    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy_out;
    logic in_xfer;

    assign rdy_out  = !out_valid_reg || !out_stall;
    assign rdy3     = !v3_reg || rdy_out;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;
    assign in_xfer  = in_valid && rdy1;
    assign out_valid = out_valid_reg;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < fir8_pkg::TAPS; k++)
            begin
                coef_reg[k] <= fir8_pkg::COEF_RESET[k];
            end
        end
        else if (wr_en && (wr_index <= fir8_pkg::REG_COEF_LAST))
        begin
            coef_reg[wr_index[fir8_pkg::TAP_BITS-1:0]] <= wr_data;
        end
    end

    // delay line: win_reg[m] is the sample m transfers old
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < fir8_pkg::TAPS; k++)
            begin
                win_reg[k] <= '0;
            end
            v1_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                win_reg[0] <= sample_in;
                for (int k = 1; k < fir8_pkg::TAPS; k++)
                begin
                    win_reg[k] <= win_reg[k-1];
                end
            end
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
        end
    end

    // coef 0 weights the newest sample, coef k the sample 8-k old
    always_comb
    begin
        for (int k = 0; k < fir8_pkg::TAPS; k++)
        begin
            prod_next[k] = coef_reg[k] * win_reg[(fir8_pkg::TAPS - k) % fir8_pkg::TAPS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (rdy2)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            for (int k = 0; k < fir8_pkg::TAPS; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
        end
    end

    always_comb
    begin
        psum_next[0] = fir8_pkg::psum_t'(prod_reg[0]) + fir8_pkg::psum_t'(prod_reg[1])
                     + fir8_pkg::psum_t'(prod_reg[2]) + fir8_pkg::psum_t'(prod_reg[3]);
        psum_next[1] = fir8_pkg::psum_t'(prod_reg[4]) + fir8_pkg::psum_t'(prod_reg[5])
                     + fir8_pkg::psum_t'(prod_reg[6]) + fir8_pkg::psum_t'(prod_reg[7]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (rdy3)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            psum_reg[0] <= psum_next[0];
            psum_reg[1] <= psum_next[1];
        end
    end

    // final sum, shift by 15, saturate
    always_comb
    begin
        acc     = fir8_pkg::acc_t'(psum_reg[0]) + fir8_pkg::acc_t'(psum_reg[1]);
        shifted = fir8_pkg::shifted_t'(acc >>> fir8_pkg::FRAC_BITS);
        if (shifted > fir8_pkg::SAT_MAX)
        begin
            sample_out_next = fir8_pkg::OUT_MAX;
            saturated_next  = 1'b1;
        end
        else if (shifted < fir8_pkg::SAT_MIN)
        begin
            sample_out_next = fir8_pkg::OUT_MIN;
            saturated_next  = 1'b1;
        end
        else
        begin
            sample_out_next = shifted[fir8_pkg::SAMPLE_W-1:0];
            saturated_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rdy_out)
        begin
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_out && v3_reg)
        begin
            sample_out <= sample_out_next;
            saturated  <= saturated_next;
        end
    end

    a_in_to_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> v1_reg)
        else $error("accepted sample did not reach window stage");

    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> (sample_out == fir8_pkg::OUT_MAX)
                                   || (sample_out == fir8_pkg::OUT_MIN))
        else $error("saturated flag without clipped value");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !v3_reg |=> !out_valid)
        else $error("output valid without data behind it");

    a_psum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !rdy_out |=> v3_reg && $stable(psum_reg[0]) && $stable(psum_reg[1]))
        else $error("partial sums changed under stall");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v1_reg && v2_reg && v3_reg && out_valid_reg)
        else $error("input stalled with an empty stage");

endmodule
